[rtl/lsp_pkg.sv]
// types, constants and helper functions shared by the line sensor position estimator
// no dependencies; every other file of the block refers to it by scoped names
`timescale 1ns / 1ps

package lsp_pkg;

    localparam int MAX_FIELDS    = 8;
    localparam int STEP_WEIGHT   = 150;
    localparam int RECIP3        = 2731;
    localparam int RECIP3_SHIFT  = 13;
    localparam int DIV_RADIX     = 4;
    localparam int DIV_STEPS     = 4;
    localparam int DIV_W         = DIV_RADIX * DIV_STEPS;
    localparam int THR_MAX       = 682;

    typedef logic [1:0]  kind_t;
    typedef logic [9:0]  sample_t;
    typedef logic [9:0]  thr_t;
    typedef logic [10:0] pos_t;
    typedef logic [3:0]  cnt_t;
    typedef logic [12:0] sum_t;
    typedef logic [1:0]  step_t;

    localparam kind_t KIND_CAL   = 2'd0;
    localparam kind_t KIND_WHITE = 2'd1;
    localparam kind_t KIND_BLACK = 2'd2;

    typedef struct packed {
        logic    active;
        logic    hit;
        pos_t    weight;
        sample_t sample;
    } lane_t;

    typedef struct packed {
        sum_t    sum;
        cnt_t    count;
        sample_t lo;
        sample_t hi;
    } merge_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // limit the sensor count to 1 .. top
    function automatic cnt_t clamp_count(cnt_t n, cnt_t top);
        cnt_t r;
        r = n;
        if (r < 4'd1)
            r = 4'd1;
        if (r > top)
            r = top;
        return r;
    endfunction

    // (n - 1) * 150 / 2
    function automatic pos_t centre_of(cnt_t n);
        logic [11:0] prod;
        prod = (12'(n) - 12'd1) * 12'(STEP_WEIGHT);
        return pos_t'(prod >> 1);
    endfunction

endpackage

[rtl/lsp_lane.sv]
// one sensor lane: flags the sample against the threshold and forms its weight
// depends on lsp_pkg
`timescale 1ns / 1ps

module lsp_lane #(
    parameter int IDX = 0
) (
    input  logic            clk,
    input  logic            load,
    input  lsp_pkg::kind_t  kind,
    input  lsp_pkg::sample_t sample,
    input  lsp_pkg::thr_t   thr,
    input  lsp_pkg::cnt_t   count,
    output lsp_pkg::lane_t  lane
);

    lsp_pkg::lane_t lane_reg;
    lsp_pkg::lane_t lane_next;
    lsp_pkg::cnt_t  rank;

    always_comb
    begin
        lane_next.active = (lsp_pkg::cnt_t'(IDX) < count);
        rank             = count - 4'd1 - lsp_pkg::cnt_t'(IDX);
        lane_next.weight = lsp_pkg::pos_t'(rank) * lsp_pkg::pos_t'(lsp_pkg::STEP_WEIGHT);
        lane_next.sample = sample;
        case (kind)
            lsp_pkg::KIND_WHITE: lane_next.hit = lane_next.active && (sample > thr);
            lsp_pkg::KIND_BLACK: lane_next.hit = lane_next.active && (sample < thr);
            default:             lane_next.hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
            lane_reg <= lane_next;
    end

    assign lane = lane_reg;

endmodule

[rtl/lsp_merge.sv]
// merging stage: weight sum, flag count and sample extremes over the active lanes
// depends on lsp_pkg
`timescale 1ns / 1ps

module lsp_merge #(
    parameter int LANES = 8
) (
    input  logic           clk,
    input  logic           load,
    input  lsp_pkg::lane_t lanes [LANES],
    output lsp_pkg::merge_t merged
);

    lsp_pkg::merge_t merged_reg;
    lsp_pkg::merge_t merged_next;

    always_comb
    begin
        merged_next.sum   = '0;
        merged_next.count = '0;
        merged_next.lo    = '1;
        merged_next.hi    = '0;
        for (int i = 0; i < LANES; i++)
        begin
            if (lanes[i].hit)
            begin
                merged_next.sum   = merged_next.sum + lsp_pkg::sum_t'(lanes[i].weight);
                merged_next.count = merged_next.count + 4'd1;
            end
            if (lanes[i].active)
            begin
                if (lanes[i].sample < merged_next.lo)
                    merged_next.lo = lanes[i].sample;
                if (lanes[i].sample > merged_next.hi)
                    merged_next.hi = lanes[i].sample;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            merged_reg <= merged_next;
    end

    assign merged = merged_reg;

endmodule

[rtl/lsp_div.sv]
// iterative restoring divider, four quotient bits per cycle
// depends on lsp_pkg; divides the weight sum by the flag count
`timescale 1ns / 1ps

module lsp_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  lsp_pkg::sum_t      dividend,
    input  lsp_pkg::cnt_t      divisor,
    output lsp_pkg::pos_t      quotient,
    output lsp_pkg::div_stat_t stat
);

    logic [lsp_pkg::DIV_W-1:0] work_reg;
    logic [lsp_pkg::DIV_W-1:0] work_next;
    lsp_pkg::cnt_t             rem_reg;
    lsp_pkg::cnt_t             rem_next;
    lsp_pkg::cnt_t             dvs_reg;
    lsp_pkg::step_t            step_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [4:0]                trial;

    always_comb
    begin
        work_next = work_reg;
        rem_next  = rem_reg;
        trial     = '0;
        for (int j = 0; j < lsp_pkg::DIV_RADIX; j++)
        begin
            trial     = {rem_next, work_next[lsp_pkg::DIV_W-1]};
            work_next = {work_next[lsp_pkg::DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next     = lsp_pkg::cnt_t'(trial - {1'b0, dvs_reg});
                work_next[0] = 1'b1;
            end
            else
            begin
                rem_next = lsp_pkg::cnt_t'(trial);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 2'd1;
            if (step_reg == lsp_pkg::step_t'(lsp_pkg::DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= lsp_pkg::DIV_W'(dividend);
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign quotient  = lsp_pkg::pos_t'(work_reg);
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[rtl/line_sensor_position_estimator_top.sv]
// top level of the line sensor position estimator
// depends on lsp_pkg, lsp_lane, lsp_merge and lsp_div
`timescale 1ns / 1ps

// Usage
// - input channel: in_valid / in_stall with kind and sample_0 .. sample_7;
//   one beat is one sweep of the sensor array
// - output channel: out_valid / out_stall with position, threshold and
//   line_seen; every input beat gives exactly one output beat
// - cfg_write / cfg_data write active_sensors and recentre the held position;
//   write only while no sweep is in flight
// - a sweep passes the lane register, the merge register, the divider load,
//   the divider steps at four quotient bits each, then the result register
// - the input takes a new sweep only in the idle state, once the divider
//   has passed the previous sweep to the output register; the next sweep is
//   taken while the previous result still waits in the output register
// - a stalled output holds its beat; a finished sweep then waits in the
//   divider stage until the output register is free, and in_stall stays high
// - reset: active_sensors = NUM_SENSORS, threshold = (2^SAMPLE_BITS - 1) / 3,
//   position at the centre of the array, no output beat pending
module line_sensor_position_estimator_top #(
    parameter int NUM_SENSORS = 8,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  lsp_pkg::kind_t         kind,
    input  lsp_pkg::sample_t       sample_0,
    input  lsp_pkg::sample_t       sample_1,
    input  lsp_pkg::sample_t       sample_2,
    input  lsp_pkg::sample_t       sample_3,
    input  lsp_pkg::sample_t       sample_4,
    input  lsp_pkg::sample_t       sample_5,
    input  lsp_pkg::sample_t       sample_6,
    input  lsp_pkg::sample_t       sample_7,
    output logic                   out_valid,
    input  logic                   out_stall,
    output lsp_pkg::pos_t          position,
    output lsp_pkg::thr_t          threshold,
    output logic                   line_seen,
    input  logic                   cfg_write,
    input  lsp_pkg::cnt_t          cfg_data
);

    localparam int LANES = (NUM_SENSORS < lsp_pkg::MAX_FIELDS) ?
                           NUM_SENSORS : lsp_pkg::MAX_FIELDS;
    localparam lsp_pkg::sample_t SAMPLE_MASK = (SAMPLE_BITS >= 10) ? 10'h3FF :
                           lsp_pkg::sample_t'((1 << SAMPLE_BITS) - 1);
    localparam lsp_pkg::thr_t THR_RESET = lsp_pkg::thr_t'(((1 << SAMPLE_BITS) - 1) / 3);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MERGE = 4'b0010,
        S_DIVGO = 4'b0100,
        S_DIV   = 4'b1000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    lsp_pkg::cnt_t      active_reg;
    lsp_pkg::thr_t      held_threshold_reg;
    lsp_pkg::pos_t      held_position_reg;
    lsp_pkg::kind_t     kind_reg;
    lsp_pkg::thr_t      thr_calc_reg;
    lsp_pkg::thr_t      thr_calc_next;
    logic               out_valid_reg;
    lsp_pkg::pos_t      position_reg;
    lsp_pkg::thr_t      threshold_reg;
    logic               line_seen_reg;

    logic               accept;
    logic               commit;
    logic               track;
    logic [22:0]        thr_prod;
    lsp_pkg::cnt_t      eff_count;
    lsp_pkg::sample_t   samp [lsp_pkg::MAX_FIELDS];
    lsp_pkg::lane_t     lane_q [LANES];
    lsp_pkg::merge_t    merged;
    lsp_pkg::pos_t      quotient;
    lsp_pkg::div_stat_t div_stat;

    assign eff_count = lsp_pkg::clamp_count(active_reg, lsp_pkg::cnt_t'(LANES));
    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);

    assign samp[0] = sample_0 & SAMPLE_MASK;
    assign samp[1] = sample_1 & SAMPLE_MASK;
    assign samp[2] = sample_2 & SAMPLE_MASK;
    assign samp[3] = sample_3 & SAMPLE_MASK;
    assign samp[4] = sample_4 & SAMPLE_MASK;
    assign samp[5] = sample_5 & SAMPLE_MASK;
    assign samp[6] = sample_6 & SAMPLE_MASK;
    assign samp[7] = sample_7 & SAMPLE_MASK;

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        lsp_lane #(
            .IDX (g)
        ) u_lane (
            .clk    (clk),
            .load   (accept),
            .kind   (kind),
            .sample (samp[g]),
            .thr    (held_threshold_reg),
            .count  (eff_count),
            .lane   (lane_q[g])
        );
    end

    lsp_merge #(
        .LANES (LANES)
    ) u_merge (
        .clk    (clk),
        .load   (state_reg == S_MERGE),
        .lanes  (lane_q),
        .merged (merged)
    );

    lsp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_DIVGO),
        .dividend (merged.sum),
        .divisor  (merged.count),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // divide by three as a reciprocal multiply, exact for sums below 2^11
    always_comb
    begin
        thr_prod      = 23'({1'b0, merged.lo} + {1'b0, merged.hi}) * 23'(lsp_pkg::RECIP3);
        thr_calc_next = lsp_pkg::thr_t'(thr_prod >> lsp_pkg::RECIP3_SHIFT);
    end

    assign track  = (kind_reg == lsp_pkg::KIND_WHITE) || (kind_reg == lsp_pkg::KIND_BLACK);
    assign commit = (state_reg == S_DIV) && div_stat.done && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_MERGE;
            S_MERGE: state_next = S_DIVGO;
            S_DIVGO: state_next = S_DIV;
            S_DIV:   if (commit) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            active_reg         <= lsp_pkg::cnt_t'(NUM_SENSORS);
            held_threshold_reg <= THR_RESET;
            held_position_reg  <= lsp_pkg::centre_of(
                lsp_pkg::clamp_count(lsp_pkg::cnt_t'(NUM_SENSORS), lsp_pkg::cnt_t'(LANES)));
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                active_reg        <= cfg_data;
                held_position_reg <= lsp_pkg::centre_of(
                    lsp_pkg::clamp_count(cfg_data, lsp_pkg::cnt_t'(LANES)));
            end
            else if (commit)
            begin
                if (kind_reg == lsp_pkg::KIND_CAL)
                    held_threshold_reg <= thr_calc_reg;
                if (track && (merged.count != '0))
                    held_position_reg <= quotient;
            end
            if (commit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            kind_reg <= kind;
        if (state_reg == S_DIVGO)
            thr_calc_reg <= thr_calc_next;
        if (commit)
        begin
            line_seen_reg <= track && (merged.count != '0);
            if (kind_reg == lsp_pkg::KIND_CAL)
                threshold_reg <= thr_calc_reg;
            else
                threshold_reg <= held_threshold_reg;
            if (track && (merged.count != '0))
                position_reg <= quotient;
            else
                position_reg <= held_position_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign position  = position_reg;
    assign threshold = threshold_reg;
    assign line_seen = line_seen_reg;

`ifndef SYNTHESIS
    a_accept_to_merge: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_MERGE))
        else $error("accepted beat did not move to the merge stage");

    a_quotient_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DIV) && div_stat.done && (merged.count != '0)) |->
        (quotient <= lsp_pkg::centre_of(eff_count) * 2'd2 + 11'd1))
        else $error("mean weight above the largest lane weight");

    a_threshold_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_threshold_reg <= lsp_pkg::thr_t'(lsp_pkg::THR_MAX))
        else $error("held threshold out of range");

    a_div_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == S_DIV))
        else $error("divider running outside the divide state");

    a_commit_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (out_valid && !in_stall))
        else $error("commit did not present a result and free the input");
`endif

endmodule

[test/tb_line_sensor_position_estimator_top.sv]
// self-checking testbench for line_sensor_position_estimator_top: directed and random sweeps,
// an in-bench estimate of position and threshold per beat; depends on rtl/lsp_pkg.sv and the rtl
`timescale 1ns / 1ps

module tb_line_sensor_position_estimator_top;

    localparam lsp_pkg::kind_t KIND_SPARE = 2'd3;
    localparam int NUM_FIELDS   = 8;
    localparam int SAMPLE_TOP   = 1023;
    localparam int THR_DIV      = 3;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_LEN     = 400;
    localparam int PHASE_ITEMS  = 110;
    localparam int NUM_PHASES   = 8;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        lsp_pkg::kind_t                  kind;
        lsp_pkg::sample_t [NUM_FIELDS-1:0] smp;
    } sweep_t;

    typedef struct packed {
        lsp_pkg::pos_t pos;
        lsp_pkg::thr_t thr;
        logic          seen;
    } est_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    lsp_pkg::kind_t   kind      = lsp_pkg::KIND_CAL;
    lsp_pkg::sample_t sample_0  = '0;
    lsp_pkg::sample_t sample_1  = '0;
    lsp_pkg::sample_t sample_2  = '0;
    lsp_pkg::sample_t sample_3  = '0;
    lsp_pkg::sample_t sample_4  = '0;
    lsp_pkg::sample_t sample_5  = '0;
    lsp_pkg::sample_t sample_6  = '0;
    lsp_pkg::sample_t sample_7  = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    lsp_pkg::pos_t    position;
    lsp_pkg::thr_t    threshold;
    logic             line_seen;
    logic             cfg_write = 1'b0;
    lsp_pkg::cnt_t    cfg_data  = '0;

    // estimator state, mirrors the block
    lsp_pkg::cnt_t trk_active = lsp_pkg::cnt_t'(NUM_FIELDS);
    lsp_pkg::thr_t trk_thr    = lsp_pkg::thr_t'(SAMPLE_TOP / THR_DIV);
    lsp_pkg::pos_t trk_pos    = lsp_pkg::pos_t'(((NUM_FIELDS - 1) * lsp_pkg::STEP_WEIGHT) / 2);

    sweep_t      sweep_q[$];
    est_t        est_q[$];
    int unsigned err_cnt       = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    logic        in_taken      = 1'b0;
    logic        hold_on       = 1'b0;
    event        hold_kick;

    line_sensor_position_estimator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .sample_0  (sample_0),
        .sample_1  (sample_1),
        .sample_2  (sample_2),
        .sample_3  (sample_3),
        .sample_4  (sample_4),
        .sample_5  (sample_5),
        .sample_6  (sample_6),
        .sample_7  (sample_7),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .position  (position),
        .threshold (threshold),
        .line_seen (line_seen),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int unsigned sensor_count(input lsp_pkg::cnt_t v);
        int unsigned n;
        n = v;
        if (n < 1)
            n = 1;
        if (n > NUM_FIELDS)
            n = NUM_FIELDS;
        return n;
    endfunction

    // updates the held threshold and position for one sweep and gives the beat it causes
    function automatic est_t estimate_sweep(input sweep_t sw);
        est_t        r;
        int unsigned n, lo, hi, acc, hits, i;
        logic        flag;
        n    = sensor_count(trk_active);
        acc  = 0;
        hits = 0;
        r.seen = 1'b0;
        if (sw.kind == lsp_pkg::KIND_CAL)
        begin
            lo = sw.smp[0];
            hi = sw.smp[0];
            for (i = 1; i < n; i++)
            begin
                if (sw.smp[i] < lo)
                    lo = sw.smp[i];
                if (sw.smp[i] > hi)
                    hi = sw.smp[i];
            end
            trk_thr = lsp_pkg::thr_t'((lo + hi) / THR_DIV);
        end
        else if (sw.kind == lsp_pkg::KIND_WHITE || sw.kind == lsp_pkg::KIND_BLACK)
        begin
            for (i = 0; i < n; i++)
            begin
                flag = (sw.kind == lsp_pkg::KIND_WHITE) ? (sw.smp[i] > trk_thr)
                                                        : (sw.smp[i] < trk_thr);
                if (flag)
                begin
                    acc  += (n - 1 - i) * lsp_pkg::STEP_WEIGHT;
                    hits += 1;
                end
            end
            if (hits > 0)
            begin
                trk_pos = lsp_pkg::pos_t'(acc / hits);
                r.seen  = 1'b1;
            end
        end
        r.pos = trk_pos;
        r.thr = trk_thr;
        return r;
    endfunction

    function automatic lsp_pkg::sample_t jitter(input int level);
        int v;
        v = level + $urandom_range(0, 60) - 30;
        if (v < 0)
            v = 0;
        if (v > SAMPLE_TOP)
            v = SAMPLE_TOP;
        return lsp_pkg::sample_t'(v);
    endfunction

    // surface level a with a line of level b over sensors at .. at+wide-1
    function automatic sweep_t line_sweep(input lsp_pkg::kind_t k, input int a, input int b,
                                          input int at, input int wide);
        sweep_t sw;
        int     i;
        sw.kind = k;
        for (i = 0; i < NUM_FIELDS; i++)
            sw.smp[i] = jitter((i >= at && i < at + wide) ? b : a);
        return sw;
    endfunction

    function automatic sweep_t flat_sweep(input lsp_pkg::kind_t k, input lsp_pkg::sample_t v);
        sweep_t sw;
        int     i;
        sw.kind = k;
        for (i = 0; i < NUM_FIELDS; i++)
            sw.smp[i] = v;
        return sw;
    endfunction

    // an optional calibrate sweep and a run of tracking sweeps over the same surface, or a noise sweep
    task automatic add_burst(output int unsigned added);
        int             a, b, len, i;
        lsp_pkg::kind_t tk;
        sweep_t         sw;
        added = 0;
        if ($urandom_range(0, 9) == 0)
        begin
            sw.kind = lsp_pkg::kind_t'($urandom_range(0, 3));
            for (i = 0; i < NUM_FIELDS; i++)
                sw.smp[i] = lsp_pkg::sample_t'($urandom_range(0, SAMPLE_TOP));
            sweep_q.push_back(sw);
            added = 1;
        end
        else
        begin
            a   = $urandom_range(0, SAMPLE_TOP);
            b   = $urandom_range(0, SAMPLE_TOP);
            len = $urandom_range(2, 8);
            // now and then the calibration is left out
            if ($urandom_range(0, 4) != 0)
            begin
                sweep_q.push_back(line_sweep(lsp_pkg::KIND_CAL, a, b,
                                             $urandom_range(0, 7), $urandom_range(1, 3)));
                added += 1;
            end
            for (i = 0; i < len; i++)
            begin
                tk = (b > a) ? lsp_pkg::KIND_WHITE : lsp_pkg::KIND_BLACK;
                if ($urandom_range(0, 7) == 0)
                    tk = (tk == lsp_pkg::KIND_WHITE) ? lsp_pkg::KIND_BLACK : lsp_pkg::KIND_WHITE;
                if ($urandom_range(0, 19) == 0)
                    tk = KIND_SPARE;
                sweep_q.push_back(line_sweep(tk, a, b, $urandom_range(0, 7),
                                             $urandom_range(1, 3)));
                added += 1;
            end
        end
    endtask

    task automatic set_active(input lsp_pkg::cnt_t v);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sweep_q.size() != 0 || in_valid || est_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // input driver: a new beat only once the current one has gone
    always @(negedge clk)
    begin
        sweep_t sw;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (sweep_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                sw = sweep_q.pop_front();
                kind     <= sw.kind;
                sample_0 <= sw.smp[0];
                sample_1 <= sw.smp[1];
                sample_2 <= sw.smp[2];
                sample_3 <= sw.smp[3];
                sample_4 <= sw.smp[4];
                sample_5 <= sw.smp[5];
                sample_6 <= sw.smp[6];
                sample_7 <= sw.smp[7];
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        out_stall <= hold_on || ($urandom_range(0, 99) < stall_pct);
    end

    // long receiver hold-off so that the block fills and stalls its input
    initial
    begin
        forever
        begin
            @(hold_kick);
            @(posedge clk);
            hold_on = 1'b1;
            repeat (HOLD_LEN) @(posedge clk);
            hold_on = 1'b0;
        end
    end

    // output check first, then the estimate for an input beat taken at this edge
    always @(posedge clk)
    begin
        est_t   got, want;
        sweep_t sw;
        if (rst_n)
        begin
            if (cfg_write)
            begin
                trk_active = cfg_data;
                trk_pos    = lsp_pkg::pos_t'(((sensor_count(cfg_data) - 1)
                                              * lsp_pkg::STEP_WEIGHT) / 2);
            end
            if (out_valid && !out_stall)
            begin
                got = '{pos: position, thr: threshold, seen: line_seen};
                if (est_q.size() == 0)
                begin
                    if (err_cnt < MAX_REPORTS)
                        $display("unexpected beat: position %0d threshold %0d line_seen %0b",
                                 got.pos, got.thr, got.seen);
                    err_cnt += 1;
                end
                else
                begin
                    want = est_q.pop_front();
                    if (got !== want)
                    begin
                        if (err_cnt < MAX_REPORTS)
                            $display({"bad beat: position %0d/%0d threshold %0d/%0d ",
                                      "line_seen %0b/%0b (expected/actual)"},
                                     want.pos, got.pos, want.thr, got.thr,
                                     want.seen, got.seen);
                        err_cnt += 1;
                    end
                end
            end
            in_taken = in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                sw.kind   = kind;
                sw.smp[0] = sample_0;
                sw.smp[1] = sample_1;
                sw.smp[2] = sample_2;
                sw.smp[3] = sample_3;
                sw.smp[4] = sample_4;
                sw.smp[5] = sample_5;
                sw.smp[6] = sample_6;
                sw.smp[7] = sample_7;
                est_q.push_back(estimate_sweep(sw));
            end
        end
    end

    initial
    begin
        #2000000;
        $display("line_sensor_position_estimator_top: mismatch");
        $finish;
    end

    initial
    begin
        sweep_t         sw;
        int unsigned    ph, got_n, added;
        lsp_pkg::cnt_t  cfg_seq [NUM_PHASES];
        cfg_seq = '{4'd1, 4'd0, 4'd5, 4'd15, 4'd8, 4'd2, 4'd9, 4'd7};

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // directed sweeps at the reset setting of eight sensors
        sweep_q.push_back(flat_sweep(lsp_pkg::KIND_WHITE, 10'h3FF));
        sw = flat_sweep(lsp_pkg::KIND_WHITE, 10'h000);
        sw.smp[0] = 10'h3FF;
        sweep_q.push_back(sw);                      // far end, largest position
        sw = flat_sweep(lsp_pkg::KIND_WHITE, 10'h000);
        sw.smp[7] = 10'h3FF;
        sweep_q.push_back(sw);                      // near end, position zero
        sweep_q.push_back(flat_sweep(lsp_pkg::KIND_BLACK, 10'h3FF));
        sw = flat_sweep(lsp_pkg::KIND_BLACK, 10'h3FF);
        sw.smp[3] = 10'h000;
        sweep_q.push_back(sw);
        sweep_q.push_back(flat_sweep(KIND_SPARE, 10'h155));
        sweep_q.push_back(flat_sweep(lsp_pkg::KIND_CAL, 10'h000));
        sweep_q.push_back(flat_sweep(lsp_pkg::KIND_BLACK, 10'h000));
        sweep_q.push_back(flat_sweep(lsp_pkg::KIND_WHITE, 10'h000));
        sweep_q.push_back(flat_sweep(lsp_pkg::KIND_CAL, 10'h3FF));
        sweep_q.push_back(flat_sweep(lsp_pkg::KIND_WHITE, 10'h3FF));
        sweep_q.push_back(flat_sweep(lsp_pkg::KIND_WHITE, 10'd682));   // equal is not above
        sw = flat_sweep(lsp_pkg::KIND_CAL, 10'd500);
        sw.smp[0] = 10'h000;
        sw.smp[7] = 10'h3FF;
        sweep_q.push_back(sw);
        sw = flat_sweep(lsp_pkg::KIND_WHITE, 10'h2AA);
        sw.smp[1] = 10'h155;
        sw.smp[3] = 10'h155;
        sw.smp[5] = 10'h155;
        sw.smp[7] = 10'h155;
        sweep_q.push_back(sw);
        sw = flat_sweep(lsp_pkg::KIND_BLACK, 10'h155);
        sw.smp[1] = 10'h2AA;
        sw.smp[3] = 10'h2AA;
        sweep_q.push_back(sw);                      // equal is not below either
        sw = flat_sweep(lsp_pkg::KIND_CAL, 10'd600);
        sw.smp[7] = 10'h000;
        sweep_q.push_back(sw);
        sw = flat_sweep(lsp_pkg::KIND_WHITE, 10'h000);
        sw.smp[2] = 10'd201;
        sw.smp[3] = 10'd201;
        sweep_q.push_back(sw);
        sweep_q.push_back(flat_sweep(KIND_SPARE, 10'h3FF));
        sweep_q.push_back(flat_sweep(lsp_pkg::KIND_BLACK, 10'h2AA));

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_idle();
            set_active(cfg_seq[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 74; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 74; end
                default: begin send_idle_pct = 12; stall_pct = 12; end
            endcase
            got_n = 0;
            while (got_n < PHASE_ITEMS)
            begin
                add_burst(added);
                got_n += added;
            end
            if (ph == 4)
                -> hold_kick;
        end

        wait_idle();
        if (err_cnt == 0 && est_q.size() == 0)
        begin
            $display("line_sensor_position_estimator_top: match");
        end
        else
        begin
            if (est_q.size() != 0)
                $display("%0d beats never arrived", est_q.size());
            $display("line_sensor_position_estimator_top: mismatch");
        end
        $finish;
    end

endmodule

[line_sensor_position_estimator_top.f]
rtl/lsp_pkg.sv
rtl/lsp_lane.sv
rtl/lsp_merge.sv
rtl/lsp_div.sv
rtl/line_sensor_position_estimator_top.sv
test/tb_line_sensor_position_estimator_top.sv
